// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the register and parser RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/bleadf_pkg.sv -----
`timescale 1ns / 1ps

package bleadf_pkg;

    localparam logic [7:0] MAX_FRAME_LEN = 8'd255;
    localparam logic [7:0] POS_MAX       = 8'hFF;

    localparam logic [7:0] TYPE_SERVICE_DATA16 = 8'h16;
    localparam logic [7:0] TYPE_NAME_COMPLETE  = 8'h09;
    localparam logic [7:0] TYPE_NAME_SHORT     = 8'h08;

    localparam logic [15:0] UUID_RESET    = 16'd6170;
    localparam logic [7:0]  SVC_LEN_RESET = 8'd18;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_UUID        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_FIELD_LENGTH = 1'd1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MALFORMED  = 2'd1,
        ST_NO_SERVICE = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] service_offset;
        logic       name_found;
        logic [7:0] name_offset;
        logic [7:0] name_length;
    } t_result;

    typedef struct packed {
        logic [15:0] expected_uuid;
        logic [7:0]  service_field_length;
    } t_cfg;

endpackage

// ----- rtl/bleadf_in_reg.sv -----
`timescale 1ns / 1ps

module bleadf_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  bleadf_pkg::t_item  i_item,
    output logic               o_valid,
    output bleadf_pkg::t_item  o_item,
    input  logic               i_take
);
    import bleadf_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

`include "assert_macros.svh"

    `ASSERT_IMPL(a_take_needs_item, i_take, r_valid, "take without a held byte")
    `ASSERT_IMPL(a_stall_needs_item, o_stall, r_valid, "stall with empty input register")

endmodule

// ----- rtl/bleadf_parser.sv -----
`timescale 1ns / 1ps

module bleadf_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bleadf_pkg::t_cfg    i_cfg,
    input  logic                i_valid,
    input  bleadf_pkg::t_item   i_item,
    input  logic                i_out_ready,
    output logic                o_take,
    output logic                o_res_valid,
    output bleadf_pkg::t_result o_res
);
    import bleadf_pkg::*;

    logic [7:0] r_pos,   n_pos;
    logic [7:0] r_rem,   n_rem;
    logic [7:0] r_len,   n_len;
    logic [7:0] r_start, n_start;
    logic [7:0] r_type,  n_type;
    logic [7:0] r_uuid_lo, n_uuid_lo;
    logic       r_mal,   n_mal;
    logic       r_svc,   n_svc;
    logic [7:0] r_svc_start, n_svc_start;
    logic       r_name,  n_name;
    logic [7:0] r_name_start, n_name_start;
    logic [7:0] r_name_chars, n_name_chars;

    logic [7:0]  w_idx;
    logic [7:0]  w_b;
    logic [15:0] w_uuid;
    logic        w_fin_mal;
    t_result     w_res;

    assign w_b    = i_item.data_byte;
    assign w_idx  = r_len - r_rem + 8'd1;
    assign w_uuid = {w_b, r_uuid_lo};

    assign o_take      = i_valid && (!i_item.last_byte || i_out_ready);
    assign o_res_valid = o_take && i_item.last_byte;

    always_comb begin
        n_pos        = r_pos;
        n_rem        = r_rem;
        n_len        = r_len;
        n_start      = r_start;
        n_type       = r_type;
        n_uuid_lo    = r_uuid_lo;
        n_mal        = r_mal;
        n_svc        = r_svc;
        n_svc_start  = r_svc_start;
        n_name       = r_name;
        n_name_start = r_name_start;
        n_name_chars = r_name_chars;
        w_fin_mal    = 1'b0;
        w_res        = '0;

        if (o_take) begin
            if (!r_mal) begin
                if (r_pos >= MAX_FRAME_LEN) begin
                    n_mal = 1'b1;
                end else if (r_rem == 8'd0) begin
                    if (w_b == 8'd0) begin
                        n_mal = 1'b1;
                    end else begin
                        n_len   = w_b;
                        n_start = r_pos;
                        n_rem   = w_b;
                        n_type  = 8'd0;
                    end
                end else begin
                    if (w_idx == 8'd1) begin
                        n_type = w_b;
                    end else if (w_idx == 8'd2) begin
                        n_uuid_lo = w_b;
                    end else if (w_idx == 8'd3) begin
                        if (r_type == TYPE_SERVICE_DATA16 &&
                            r_len == i_cfg.service_field_length &&
                            w_uuid == i_cfg.expected_uuid) begin
                            n_svc       = 1'b1;
                            n_svc_start = r_start;
                        end
                    end
                    n_rem = r_rem - 8'd1;
                    if (n_rem == 8'd0 &&
                        (n_type == TYPE_NAME_COMPLETE || n_type == TYPE_NAME_SHORT)) begin
                        n_name       = 1'b1;
                        n_name_start = r_start + 8'd2;
                        n_name_chars = r_len - 8'd1;
                    end
                end
            end
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 8'd1;
            end

            if (i_item.last_byte) begin
                w_fin_mal = n_mal || (n_rem != 8'd0);
                if (w_fin_mal) begin
                    w_res.status = ST_MALFORMED;
                end else if (n_svc) begin
                    w_res.status         = ST_OK;
                    w_res.service_offset = n_svc_start;
                end else begin
                    w_res.status = ST_NO_SERVICE;
                end
                if (n_name) begin
                    w_res.name_found  = 1'b1;
                    w_res.name_offset = n_name_start;
                    w_res.name_length = n_name_chars;
                end
                // frame done: clear per-frame state
                n_pos        = 8'd0;
                n_rem        = 8'd0;
                n_len        = 8'd0;
                n_start      = 8'd0;
                n_type       = 8'd0;
                n_uuid_lo    = 8'd0;
                n_mal        = 1'b0;
                n_svc        = 1'b0;
                n_svc_start  = 8'd0;
                n_name       = 1'b0;
                n_name_start = 8'd0;
                n_name_chars = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 8'd0;
            r_rem        <= 8'd0;
            r_len        <= 8'd0;
            r_start      <= 8'd0;
            r_type       <= 8'd0;
            r_uuid_lo    <= 8'd0;
            r_mal        <= 1'b0;
            r_svc        <= 1'b0;
            r_svc_start  <= 8'd0;
            r_name       <= 1'b0;
            r_name_start <= 8'd0;
            r_name_chars <= 8'd0;
        end else begin
            r_pos        <= n_pos;
            r_rem        <= n_rem;
            r_len        <= n_len;
            r_start      <= n_start;
            r_type       <= n_type;
            r_uuid_lo    <= n_uuid_lo;
            r_mal        <= n_mal;
            r_svc        <= n_svc;
            r_svc_start  <= n_svc_start;
            r_name       <= n_name;
            r_name_start <= n_name_start;
            r_name_chars <= n_name_chars;
        end
    end

    assign o_res = w_res;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_frame_cleared, o_res_valid, r_pos == 8'd0 && !r_mal && !r_svc,
        "frame state not cleared after last byte")
    `ASSERT_IMPL(a_result_has_room, o_res_valid, i_out_ready,
        "result produced while output register is blocked")
    `ASSERT_IMPL(a_rem_within_len, r_rem != 8'd0, r_rem <= r_len,
        "field remaining count exceeds field length")

endmodule

// ----- rtl/bleadf_out_reg.sv -----
`timescale 1ns / 1ps

module bleadf_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  bleadf_pkg::t_result i_res,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_stall,
    output bleadf_pkg::t_result o_res
);
    import bleadf_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`include "assert_macros.svh"

    `ASSERT_CLK(a_no_overwrite, !(i_res_valid && r_valid && i_stall),
        "pending result overwritten")

endmodule

// ----- rtl/ble_adv_service_data_finder_unit.sv -----
`timescale 1ns / 1ps

// Advertising payload parser: finds the configured 16-bit service-data field and
// the last local-name field in one BLE advertising frame.
// Input channel: one payload byte per transfer (i_data_byte, i_last_byte marks the
// final byte), handshake i_in_valid / o_in_stall.
// Output channel: one result per frame, sent for the transfer that carried the last
// byte; handshake o_out_valid / i_out_stall, fields o_status .. o_name_length.
// Throughput: one byte per cycle save stalls on a last byte; no gap between frames.
// Path: a byte is held in the input register; the result of a frame is computed
// when the parser takes the last byte and is registered in the output register.
// Stall: while a result waits in the output register, bytes without the last mark
// keep flowing; a last byte waits in the input register until the result leaves.
// Reset (synchronous, active low) clears all frame state and restores the
// configuration registers: UUID 6170, service field length 18.
// Configuration: i_cfg_we with i_cfg_index (0 UUID, 1 field length) and
// i_cfg_data; write only while no frame is in flight.
module ble_adv_service_data_finder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [7:0]                          o_service_offset,
    output logic                                o_name_found,
    output logic [7:0]                          o_name_offset,
    output logic [7:0]                          o_name_length,
    input  logic                                i_cfg_we,
    input  logic [bleadf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bleadf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bleadf_pkg::*;

    t_cfg    r_cfg;
    t_item   w_in_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_take;
    logic    w_out_ready;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_uuid        <= UUID_RESET;
            r_cfg.service_field_length <= SVC_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_UUID: begin
                    r_cfg.expected_uuid <= i_cfg_data;
                end
                CFG_SERVICE_FIELD_LENGTH: begin
                    r_cfg.service_field_length <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_in_item.data_byte = i_data_byte;
    assign w_in_item.last_byte = i_last_byte;

    bleadf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .o_valid (w_held_valid),
        .o_item  (w_held_item),
        .i_take  (w_take)
    );

    bleadf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_held_valid),
        .i_item      (w_held_item),
        .i_out_ready (w_out_ready),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    bleadf_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_ready     (w_out_ready),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_res       (w_out_res)
    );

    assign o_status         = w_out_res.status;
    assign o_service_offset = w_out_res.service_offset;
    assign o_name_found     = w_out_res.name_found;
    assign o_name_offset    = w_out_res.name_offset;
    assign o_name_length    = w_out_res.name_length;

endmodule

// ----- bench/ble_adv_service_data_finder_unit_test.sv -----
`timescale 1ns / 1ps

module ble_adv_service_data_finder_unit_test;
    import bleadf_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  i_last_byte = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_status;
    logic [7:0]            o_service_offset;
    logic                  o_name_found;
    logic [7:0]            o_name_offset;
    logic [7:0]            o_name_length;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ble_adv_service_data_finder_unit DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // byte stream waiting to be sent and results still owed by the block
    t_item      tx_bytes[$];
    t_result    frame_reports[$];
    logic [7:0] frame_buf[$];
    int         queued_bytes = 0;
    int         errors = 0;

    // predictor: configuration and per-frame parse state
    logic [15:0] cfg_uuid;
    logic [7:0]  cfg_svc_len;
    logic [7:0]  pos, remain, flen, fstart, ftype, uuid_lo;
    logic        bad, svc_hit, name_hit;
    logic [7:0]  svc_at, name_at, name_len;

    function automatic void clear_frame_state();
        pos = 0; remain = 0; flen = 0; fstart = 0; ftype = 0; uuid_lo = 0;
        bad = 0; svc_hit = 0; svc_at = 0; name_hit = 0; name_at = 0; name_len = 0;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        int      idx;
        t_result r;
        if (!bad) begin
            if (pos >= MAX_FRAME_LEN) begin
                bad = 1'b1;
            end else if (remain == 0) begin
                if (b == 8'h00) begin
                    bad = 1'b1;
                end else begin
                    flen = b;
                    fstart = pos;
                    remain = b;
                    ftype = 8'h00;
                end
            end else begin
                idx = int'(flen) - int'(remain) + 1;
                if (idx == 1) begin
                    ftype = b;
                end else if (idx == 2) begin
                    uuid_lo = b;
                end else if (idx == 3) begin
                    if (ftype == TYPE_SERVICE_DATA16 && flen == cfg_svc_len &&
                        {b, uuid_lo} == cfg_uuid) begin
                        svc_hit = 1'b1;
                        svc_at = fstart;
                    end
                end
                remain = remain - 8'd1;
                if (remain == 0 && (ftype == TYPE_NAME_COMPLETE || ftype == TYPE_NAME_SHORT)) begin
                    name_hit = 1'b1;
                    name_at = fstart + 8'd2;
                    name_len = flen - 8'd1;
                end
            end
        end
        if (pos != POS_MAX) pos = pos + 8'd1;
        if (last) begin
            if (remain != 0) bad = 1'b1;
            r.status = bad ? ST_MALFORMED : (svc_hit ? ST_OK : ST_NO_SERVICE);
            r.service_offset = (r.status == ST_OK) ? svc_at : 8'h00;
            r.name_found = name_hit;
            r.name_offset = name_hit ? name_at : 8'h00;
            r.name_length = name_hit ? name_len : 8'h00;
            frame_reports.push_back(r);
            clear_frame_state();
        end
    endtask

    // sender
    int   send_wait = 0;
    logic sender_busy = 1'b1;

    always @(posedge i_clk) begin : byte_driver
        t_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) parse_byte(i_data_byte, i_last_byte);
            if (!i_in_valid || !o_in_stall) begin
                if (send_wait != 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (tx_bytes.size() != 0) begin
                    nxt = tx_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= nxt.data_byte;
                    i_last_byte <= nxt.last_byte;
                    if ($urandom_range(0, 63) == 0) sender_busy = !sender_busy;
                    send_wait = sender_busy ? $urandom_range(0, 14) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    int   stall_wait = 0;
    logic receiver_busy = 1'b1;

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (frame_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, o_status);
                    errors++;
                end else begin
                    want = frame_reports.pop_front();
                    compare_field("status", 8'(want.status), 8'(o_status));
                    compare_field("service_offset", want.service_offset, o_service_offset);
                    compare_field("name_found", 8'(want.name_found), 8'(o_name_found));
                    compare_field("name_offset", want.name_offset, o_name_offset);
                    compare_field("name_length", want.name_length, o_name_length);
                end
                if ($urandom_range(0, 15) == 0) receiver_busy = !receiver_busy;
                stall_wait = receiver_busy ? $urandom_range(0, 14) : 0;
            end
            if (stall_wait != 0) begin
                stall_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // frame building
    task automatic post_frame();
        t_item it;
        foreach (frame_buf[i]) begin
            it.data_byte = frame_buf[i];
            it.last_byte = (i == frame_buf.size() - 1);
            tx_bytes.push_back(it);
        end
        queued_bytes += frame_buf.size();
        frame_buf.delete();
    endtask

    task automatic add_field(input logic [7:0] len, input logic [7:0] kind);
        frame_buf.push_back(len);
        frame_buf.push_back(kind);
        for (int i = 2; i <= len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_service(input logic [7:0] len, input logic [15:0] uuid);
        frame_buf.push_back(len);
        frame_buf.push_back(TYPE_SERVICE_DATA16);
        for (int i = 2; i <= len; i++) begin
            if (i == 2) frame_buf.push_back(uuid[7:0]);
            else if (i == 3) frame_buf.push_back(uuid[15:8]);
            else frame_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // pad with unrelated fields until the frame is exactly target bytes long
    task automatic filler_to(input int target);
        int r, len;
        while (frame_buf.size() < target) begin
            r = target - frame_buf.size();
            if (r - 1 <= 12) len = r - 1;
            else if (r - 13 == 1) len = 11;
            else len = 12;
            add_field(8'(len), 8'hFF);
        end
    endtask

    task automatic random_frame();
        int n, pick, len;
        n = $urandom_range(0, 4);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) len = cfg_svc_len + 1;
            else len = 13;
            if (frame_buf.size() + len + 1 <= 255) begin
                if (pick < 25) begin
                    add_service(cfg_svc_len, cfg_uuid);
                end else if (pick < 35) begin
                    add_service(cfg_svc_len, cfg_uuid ^ (16'h1 << $urandom_range(0, 15)));
                end else if (pick < 42) begin
                    len = $urandom_range(0, 1) ? cfg_svc_len + 1 : cfg_svc_len - 1;
                    if (len < 1) len = 1;
                    if (len > 254) len = 254;
                    add_service(8'(len), cfg_uuid);
                end else if (pick < 60) begin
                    add_field(8'($urandom_range(1, 12)),
                              $urandom_range(0, 1) ? TYPE_NAME_COMPLETE : TYPE_NAME_SHORT);
                end else if (pick < 80) begin
                    add_field(8'($urandom_range(1, 8)), 8'($urandom_range(0, 255)));
                end else begin
                    add_service(8'($urandom_range(1, 6)), 16'($urandom));
                end
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            frame_buf.push_back(8'h00);
            repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 16 && frame_buf.size() > 1) begin
            repeat ($urandom_range(1, frame_buf.size() > 4 ? 4 : frame_buf.size() - 1))
                void'(frame_buf.pop_back());
        end else if (pick < 22) begin
            repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (frame_buf.size() == 0) frame_buf.push_back(8'($urandom_range(0, 255)));
        post_frame();
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (tx_bytes.size() != 0 || i_in_valid || frame_reports.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_frames(input int budget);
        int target;
        target = queued_bytes + budget;
        while (queued_bytes < target) begin
            random_frame();
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_EXPECTED_UUID) cfg_uuid = data;
        else if (idx == CFG_SERVICE_FIELD_LENGTH) cfg_svc_len = data[7:0];
    endtask

    initial begin
        cfg_uuid = UUID_RESET;
        cfg_svc_len = SVC_LEN_RESET;
        clear_frame_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: zero length, plain field, names, overrun
        frame_buf.push_back(8'h00);
        post_frame();
        add_field(8'd2, 8'h01);
        frame_buf[2] = 8'hFF;
        post_frame();
        add_field(8'd2, TYPE_NAME_SHORT);
        add_field(8'd3, TYPE_NAME_COMPLETE);
        post_frame();
        add_field(8'd3, TYPE_NAME_COMPLETE);
        frame_buf.push_back(8'd5);
        frame_buf.push_back(TYPE_SERVICE_DATA16);
        frame_buf.push_back(8'h1A);
        post_frame();
        add_field(8'd2, 8'h01);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'h05);
        post_frame();
        random_frames(50);
        wait_drained();

        write_cfg(CFG_EXPECTED_UUID, 16'h0000);
        write_cfg(CFG_SERVICE_FIELD_LENGTH, 16'd3);
        add_service(8'd3, 16'h0000);
        add_service(8'd3, 16'h0000);
        post_frame();
        add_service(8'd3, 16'h0100);
        post_frame();
        add_service(8'd4, 16'h0000);
        post_frame();
        random_frames(30);
        wait_drained();

        write_cfg(CFG_EXPECTED_UUID, 16'hFFFF);
        write_cfg(CFG_SERVICE_FIELD_LENGTH, 16'd254);
        add_service(8'd254, 16'hFFFF);
        post_frame();
        add_field(8'd254, TYPE_NAME_COMPLETE);
        post_frame();
        // name field ending on the last allowed offset, then one byte too many
        filler_to(253);
        add_field(8'd1, TYPE_NAME_COMPLETE);
        frame_buf.push_back(8'd2);
        post_frame();
        random_frames(25);
        wait_drained();

        // configured length too short to hold the UUID
        write_cfg(CFG_SERVICE_FIELD_LENGTH, 16'd2);
        random_frames(25);
        wait_drained();

        repeat (3) begin
            write_cfg(CFG_EXPECTED_UUID, 16'($urandom));
            write_cfg(CFG_SERVICE_FIELD_LENGTH, 16'($urandom_range(3, 24)));
            random_frames(25);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
